// ===== rtl/bmh_pkg.sv =====
// shared constants, codes and controller/datapath command types of the min-heap queue
package bmh_pkg;

    localparam int HEAP_DEPTH_DEF = 256;
    localparam int KEY_BITS_DEF   = 6;
    localparam int TAG_BITS_DEF   = 16;
    localparam int STATUS_BITS    = 2;

    localparam logic OP_INSERT  = 1'b0;
    localparam logic OP_EXTRACT = 1'b1;

    localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd2;

    // commands from the controller to the datapath
    typedef struct packed {
        logic accept;     // latch the request word
        logic set_full;   // refuse insert
        logic set_empty;  // refuse extract
        logic ins_begin;  // hole at the end, count up
        logic ext_begin;  // read root and last entry, count down
        logic ext_load;   // take root as result, last entry starts sifting down
        logic rd_up;      // read parent of the hole
        logic up_step;    // move parent down or settle the entry
        logic rd_dn;      // read both children of the hole
        logic dn_step;    // move smaller child up or settle the entry
        logic wr_x;       // settle the sifting entry at the hole
        logic load_out;   // load the response register
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic op;
        logic full;
        logic empty;
        logic pos_zero;
        logic up_swap;
        logic dn_leaf;
        logic dn_move;
    } t_sts;

endpackage

// ===== rtl/bmh_if.sv =====
// request and response channel interfaces of the min-heap queue
interface bmh_req_if #(
    parameter int KEY_BITS = bmh_pkg::KEY_BITS_DEF,
    parameter int TAG_BITS = bmh_pkg::TAG_BITS_DEF
);
    logic                valid;
    logic                ready;
    logic                op;
    logic [KEY_BITS-1:0] key;
    logic [TAG_BITS-1:0] tag;

    modport source (output valid, output op, output key, output tag, input ready);
    modport sink   (input valid, input op, input key, input tag, output ready);
endinterface

interface bmh_rsp_if #(
    parameter int KEY_BITS  = bmh_pkg::KEY_BITS_DEF,
    parameter int TAG_BITS  = bmh_pkg::TAG_BITS_DEF,
    parameter int FILL_BITS = $clog2(bmh_pkg::HEAP_DEPTH_DEF + 1)
);
    logic                               valid;
    logic                               ready;
    logic [bmh_pkg::STATUS_BITS-1:0]    status;
    logic [KEY_BITS-1:0]                out_key;
    logic [TAG_BITS-1:0]                out_tag;
    logic [FILL_BITS-1:0]               fill;

    modport source (output valid, output status, output out_key, output out_tag,
                    output fill, input ready);
    modport sink   (input valid, input status, input out_key, input out_tag,
                    input fill, output ready);
endinterface

// ===== rtl/bmh_datapath.sv =====
// heap storage, hole position, entry count and response registers
module bmh_datapath #(
    parameter int HEAP_DEPTH = bmh_pkg::HEAP_DEPTH_DEF,
    parameter int KEY_BITS   = bmh_pkg::KEY_BITS_DEF,
    parameter int TAG_BITS   = bmh_pkg::TAG_BITS_DEF,
    parameter int FILL_BITS  = $clog2(HEAP_DEPTH + 1)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  bmh_pkg::t_cmd                     i_cmd,
    output bmh_pkg::t_sts                     o_sts,
    input  logic                              i_op,
    input  logic [KEY_BITS-1:0]               i_key,
    input  logic [TAG_BITS-1:0]               i_tag,
    output logic [bmh_pkg::STATUS_BITS-1:0]   o_status,
    output logic [KEY_BITS-1:0]               o_out_key,
    output logic [TAG_BITS-1:0]               o_out_tag,
    output logic [FILL_BITS-1:0]              o_fill
);
    import bmh_pkg::*;

    localparam int AW = $clog2(HEAP_DEPTH);
    localparam int CW = FILL_BITS;
    localparam int LW = AW + 2;
    localparam int EW = KEY_BITS + TAG_BITS;
    localparam logic [CW-1:0] FULL_COUNT = CW'(HEAP_DEPTH);

    logic [EW-1:0]          r_mem [HEAP_DEPTH];
    logic [EW-1:0]          r_rd_a;
    logic [EW-1:0]          r_rd_b;
    logic [CW-1:0]          r_count;
    logic [AW-1:0]          r_pos;
    logic                   r_op;
    logic [KEY_BITS-1:0]    r_x_key;
    logic [TAG_BITS-1:0]    r_x_tag;
    logic [STATUS_BITS-1:0] r_res_status;
    logic [KEY_BITS-1:0]    r_res_key;
    logic [TAG_BITS-1:0]    r_res_tag;
    logic [STATUS_BITS-1:0] r_out_status;
    logic [KEY_BITS-1:0]    r_out_key;
    logic [TAG_BITS-1:0]    r_out_tag;
    logic [CW-1:0]          r_out_fill;

    logic [AW-1:0]       w_parent;
    logic [LW-1:0]       w_lc;
    logic [LW-1:0]       w_rc;
    logic [LW-1:0]       w_count_ext;
    logic [CW-1:0]       w_last;
    logic                w_lc_ok;
    logic                w_rc_ok;
    logic                w_lv;
    logic                w_rv;
    logic [KEY_BITS-1:0] w_a_key;
    logic [KEY_BITS-1:0] w_b_key;
    logic [KEY_BITS-1:0] w_min_key;
    logic                w_up_swap;
    logic                w_rd_en;
    logic [AW-1:0]       w_rd_addr_a;
    logic [AW-1:0]       w_rd_addr_b;
    logic                w_wr_en;
    logic [EW-1:0]       w_wr_data;

    assign w_parent    = (r_pos - AW'(1)) >> 1;
    assign w_lc        = {1'b0, r_pos, 1'b1};
    assign w_rc        = w_lc + LW'(1);
    assign w_count_ext = LW'(r_count);
    assign w_last      = r_count - CW'(1);
    assign w_lc_ok     = w_lc < w_count_ext;
    assign w_rc_ok     = w_rc < w_count_ext;

    assign w_a_key   = r_rd_a[EW-1:TAG_BITS];
    assign w_b_key   = r_rd_b[EW-1:TAG_BITS];
    assign w_up_swap = w_a_key > r_x_key;
    // left child first, then right child against the smaller so far
    assign w_lv      = w_lc_ok && (w_a_key < r_x_key);
    assign w_min_key = w_lv ? w_a_key : r_x_key;
    assign w_rv      = w_rc_ok && (w_b_key < w_min_key);

    always_comb begin
        w_rd_en     = 1'b0;
        w_rd_addr_a = w_lc[AW-1:0];
        w_rd_addr_b = w_rc[AW-1:0];
        if (i_cmd.ext_begin) begin
            w_rd_en     = 1'b1;
            w_rd_addr_a = '0;
            w_rd_addr_b = w_last[AW-1:0];
        end else if (i_cmd.rd_up) begin
            w_rd_en     = 1'b1;
            w_rd_addr_a = w_parent;
        end else if (i_cmd.rd_dn) begin
            w_rd_en     = 1'b1;
        end
    end

    always_comb begin
        w_wr_en   = i_cmd.wr_x | i_cmd.up_step | i_cmd.dn_step;
        w_wr_data = {r_x_key, r_x_tag};
        if (i_cmd.up_step && w_up_swap) begin
            w_wr_data = r_rd_a;
        end else if (i_cmd.dn_step && w_rv) begin
            w_wr_data = r_rd_b;
        end else if (i_cmd.dn_step && w_lv) begin
            w_wr_data = r_rd_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_pos] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rd_a <= r_mem[w_rd_addr_a];
            r_rd_b <= r_mem[w_rd_addr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.ins_begin) begin
            r_count <= r_count + CW'(1);
        end else if (i_cmd.ext_begin) begin
            r_count <= w_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op         <= i_op;
            r_x_key      <= i_key;
            r_x_tag      <= i_tag;
            r_res_status <= ST_OK;
            r_res_key    <= '0;
            r_res_tag    <= '0;
        end
        if (i_cmd.set_full) begin
            r_res_status <= ST_FULL;
        end
        if (i_cmd.set_empty) begin
            r_res_status <= ST_EMPTY;
        end
        if (i_cmd.ins_begin) begin
            r_pos <= r_count[AW-1:0];
        end
        if (i_cmd.ext_load) begin
            r_res_key <= r_rd_a[EW-1:TAG_BITS];
            r_res_tag <= r_rd_a[TAG_BITS-1:0];
            r_x_key   <= r_rd_b[EW-1:TAG_BITS];
            r_x_tag   <= r_rd_b[TAG_BITS-1:0];
            r_pos     <= '0;
        end
        if (i_cmd.up_step && w_up_swap) begin
            r_pos <= w_parent;
        end
        if (i_cmd.dn_step && w_rv) begin
            r_pos <= w_rc[AW-1:0];
        end else if (i_cmd.dn_step && w_lv) begin
            r_pos <= w_lc[AW-1:0];
        end
        if (i_cmd.load_out) begin
            r_out_status <= r_res_status;
            r_out_key    <= r_res_key;
            r_out_tag    <= r_res_tag;
            r_out_fill   <= r_count;
        end
    end

    assign o_sts.op       = r_op;
    assign o_sts.full     = r_count == FULL_COUNT;
    assign o_sts.empty    = r_count == '0;
    assign o_sts.pos_zero = r_pos == '0;
    assign o_sts.up_swap  = w_up_swap;
    assign o_sts.dn_leaf  = !w_lc_ok;
    assign o_sts.dn_move  = w_lv | w_rv;

    assign o_status  = r_out_status;
    assign o_out_key = r_out_key;
    assign o_out_tag = r_out_tag;
    assign o_fill    = r_out_fill;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_COUNT)
        else $error("entry count beyond heap depth");

    a_no_insert_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ins_begin |-> !o_sts.full)
        else $error("insert started on a full heap");

    a_no_extract_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ext_begin |-> !o_sts.empty)
        else $error("extract started on an empty heap");

    a_count_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ext_begin |=> r_count == $past(r_count) - CW'(1))
        else $error("extract did not take one entry");

    a_count_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.up_step || i_cmd.dn_step || i_cmd.wr_x) |=> $stable(r_count))
        else $error("entry count moved during a sift");

endmodule

// ===== rtl/bmh_ctrl.sv =====
// sequencer of insert sift-up and extract sift-down
module bmh_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output bmh_pkg::t_cmd o_cmd,
    input  bmh_pkg::t_sts i_sts
);
    import bmh_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_EXT_CHK,
        S_UP_RD,
        S_UP_CMP,
        S_DN_RD,
        S_DN_CMP,
        S_FIN
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        n_state    = r_state;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (i_sts.op == OP_INSERT) begin
                    if (i_sts.full) begin
                        o_cmd.set_full = 1'b1;
                        n_state        = S_FIN;
                    end else begin
                        o_cmd.ins_begin = 1'b1;
                        n_state         = S_UP_RD;
                    end
                end else begin
                    if (i_sts.empty) begin
                        o_cmd.set_empty = 1'b1;
                        n_state         = S_FIN;
                    end else begin
                        o_cmd.ext_begin = 1'b1;
                        n_state         = S_EXT_CHK;
                    end
                end
            end
            S_EXT_CHK: begin
                o_cmd.ext_load = 1'b1;
                n_state        = S_DN_RD;
            end
            S_UP_RD: begin
                if (i_sts.pos_zero) begin
                    o_cmd.wr_x = 1'b1;
                    n_state    = S_FIN;
                end else begin
                    o_cmd.rd_up = 1'b1;
                    n_state     = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                o_cmd.up_step = 1'b1;
                n_state       = i_sts.up_swap ? S_UP_RD : S_FIN;
            end
            S_DN_RD: begin
                if (i_sts.dn_leaf) begin
                    o_cmd.wr_x = 1'b1;
                    n_state    = S_FIN;
                end else begin
                    o_cmd.rd_dn = 1'b1;
                    n_state     = S_DN_CMP;
                end
            end
            S_DN_CMP: begin
                o_cmd.dn_step = 1'b1;
                n_state       = i_sts.dn_move ? S_DN_RD : S_FIN;
            end
            S_FIN: begin
                // wait for the response register to free up
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> (!r_out_valid || i_out_ready))
        else $error("response word overwritten before it was taken");

    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> r_state == S_DISPATCH)
        else $error("accepted request not dispatched");

    a_fin_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && n_state == S_IDLE) |=> r_out_valid)
        else $error("operation finished without a response word");

endmodule

// ===== rtl/binary_min_heap_priority_queue.sv =====
// Binary min-heap priority queue of key/tag entries, top level.
//
// i_req carries one request word: op (insert or extract minimum), key and tag.
// o_rsp returns exactly one response word per request: status, out_key,
// out_tag and fill, the entry count after the operation.
// Equal keys leave in the order fixed by strict compares: sift-up swaps only
// while the parent key is greater, sift-down tries the left child first.
// A request is taken only while the sequencer is idle; one operation is in
// flight at a time. The next request can be taken in the cycle after the
// response word is loaded. A refused request goes from dispatch straight to
// the finish. Each level of a sift is one registered memory read and one
// compare with a write. Insert climbs until the parent key is not greater or
// it reaches the root; extract descends until no child is smaller or it ends
// at a leaf. At 256 entries the slowest operation is an insert that climbs
// all eight levels.
// The response sits in an output register; a new request is accepted while
// it waits, and a stalled receiver only holds the next finish.
// Reset clears the entry count and the handshake state; the heap memory is
// not cleared, since entries at or above the count are never used.
module binary_min_heap_priority_queue #(
    parameter int HEAP_DEPTH = bmh_pkg::HEAP_DEPTH_DEF,
    parameter int KEY_BITS   = bmh_pkg::KEY_BITS_DEF,
    parameter int TAG_BITS   = bmh_pkg::TAG_BITS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    bmh_req_if.sink   i_req,
    bmh_rsp_if.source o_rsp
);
    import bmh_pkg::*;

    localparam int FILL_BITS = $clog2(HEAP_DEPTH + 1);

    t_cmd w_cmd;
    t_sts w_sts;

    bmh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    bmh_datapath #(
        .HEAP_DEPTH (HEAP_DEPTH),
        .KEY_BITS   (KEY_BITS),
        .TAG_BITS   (TAG_BITS),
        .FILL_BITS  (FILL_BITS)
    ) u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .o_sts     (w_sts),
        .i_op      (i_req.op),
        .i_key     (i_req.key),
        .i_tag     (i_req.tag),
        .o_status  (o_rsp.status),
        .o_out_key (o_rsp.out_key),
        .o_out_tag (o_rsp.out_tag),
        .o_fill    (o_rsp.fill)
    );

endmodule

// ===== tb/tb_binary_min_heap_priority_queue.sv =====
// testbench of the min-heap queue: directed table, then random words checked against a heap predictor
module tb_binary_min_heap_priority_queue;
    timeunit 1ns;
    timeprecision 1ps;

    import bmh_pkg::*;

    localparam int DEPTH  = HEAP_DEPTH_DEF;
    localparam int KW     = KEY_BITS_DEF;
    localparam int TW     = TAG_BITS_DEF;
    localparam int FW     = $clog2(HEAP_DEPTH_DEF + 1);
    localparam int N_DIR  = 25;
    localparam int N_MIX  = 100;
    localparam int N_TAIL = 30;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [KW-1:0]          out_key;
        logic [TW-1:0]          out_tag;
        logic [FW-1:0]          fill;
    } t_rsp_word;

    typedef struct packed {
        logic [KW-1:0] key;
        logic [TW-1:0] tag;
    } t_heap_entry;

    typedef struct packed {
        logic      op;
        logic [KW-1:0] key;
        logic [TW-1:0] tag;
        logic      typed;
        t_rsp_word want;
    } t_stim_row;

    // typed rows carry the response that can be read off directly, the rest use the predictor
    localparam t_stim_row DIR_ROWS [N_DIR] = '{
        '{OP_EXTRACT, 6'd0,  16'h0000, 1'b1, '{ST_EMPTY, 6'd0,  16'h0000, 9'd0}},
        '{OP_INSERT,  6'd63, 16'hffff, 1'b1, '{ST_OK,    6'd0,  16'h0000, 9'd1}},
        '{OP_INSERT,  6'd0,  16'h0000, 1'b1, '{ST_OK,    6'd0,  16'h0000, 9'd2}},
        '{OP_EXTRACT, 6'd0,  16'h0000, 1'b1, '{ST_OK,    6'd0,  16'h0000, 9'd1}},
        '{OP_EXTRACT, 6'd0,  16'h0000, 1'b1, '{ST_OK,    6'd63, 16'hffff, 9'd0}},
        '{OP_EXTRACT, 6'd0,  16'h0000, 1'b1, '{ST_EMPTY, 6'd0,  16'h0000, 9'd0}},
        // equal keys, exit order set by the strict compares
        '{OP_INSERT,  6'd5,  16'h0001, 1'b0, '0},
        '{OP_INSERT,  6'd5,  16'h0002, 1'b0, '0},
        '{OP_INSERT,  6'd5,  16'h0003, 1'b0, '0},
        '{OP_INSERT,  6'd5,  16'h0004, 1'b0, '0},
        '{OP_INSERT,  6'd5,  16'h0005, 1'b0, '0},
        '{OP_INSERT,  6'd3,  16'h0006, 1'b0, '0},
        '{OP_INSERT,  6'd5,  16'h0007, 1'b0, '0},
        '{OP_INSERT,  6'd63, 16'haaaa, 1'b0, '0},
        '{OP_INSERT,  6'd0,  16'h5555, 1'b0, '0},
        '{OP_EXTRACT, 6'd0,  16'h0000, 1'b0, '0},
        '{OP_EXTRACT, 6'd63, 16'hffff, 1'b0, '0},
        '{OP_EXTRACT, 6'd0,  16'h0000, 1'b0, '0},
        '{OP_EXTRACT, 6'd0,  16'h0000, 1'b0, '0},
        '{OP_EXTRACT, 6'd0,  16'h0000, 1'b0, '0},
        '{OP_EXTRACT, 6'd0,  16'h0000, 1'b0, '0},
        '{OP_EXTRACT, 6'd0,  16'h0000, 1'b0, '0},
        '{OP_EXTRACT, 6'd0,  16'h0000, 1'b0, '0},
        '{OP_EXTRACT, 6'd0,  16'h0000, 1'b0, '0},
        '{OP_EXTRACT, 6'd0,  16'h0000, 1'b1, '{ST_EMPTY, 6'd0,  16'h0000, 9'd0}}
    };

    logic i_clk;
    logic i_rst_n;

    bmh_req_if req_if ();
    bmh_rsp_if rsp_if ();

    binary_min_heap_priority_queue i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    t_heap_entry heap_mem [DEPTH];
    int          heap_fill;
    t_rsp_word   pending_rsp [$];
    int          fail_count;
    int          words_sent;
    int          gap_pct;
    bit          quiet;

    initial begin
        i_clk = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    // heap predictor: applies one request word, returns the response it causes
    function automatic t_rsp_word heap_apply(input logic op, input logic [KW-1:0] key,
                                             input logic [TW-1:0] tag);
        t_rsp_word   r;
        t_heap_entry t;
        int          pos;
        int          up;
        int          best;
        int          lc;
        int          rc;
        r = '0;
        r.status = ST_OK;
        if (op == OP_INSERT) begin
            if (heap_fill >= DEPTH) begin
                r.status = ST_FULL;
            end else begin
                heap_mem[heap_fill] = '{key, tag};
                pos = heap_fill;
                heap_fill++;
                while (pos > 0) begin
                    up = (pos - 1) / 2;
                    if (heap_mem[up].key > heap_mem[pos].key) begin
                        t = heap_mem[up];
                        heap_mem[up] = heap_mem[pos];
                        heap_mem[pos] = t;
                        pos = up;
                    end else begin
                        break;
                    end
                end
            end
        end else if (heap_fill == 0) begin
            r.status = ST_EMPTY;
        end else begin
            r.out_key = heap_mem[0].key;
            r.out_tag = heap_mem[0].tag;
            heap_mem[0] = heap_mem[heap_fill - 1];
            heap_fill--;
            pos = 0;
            while (pos < heap_fill) begin
                best = pos;
                lc = 2 * pos + 1;
                rc = 2 * pos + 2;
                if (lc < heap_fill && heap_mem[lc].key < heap_mem[best].key) best = lc;
                if (rc < heap_fill && heap_mem[rc].key < heap_mem[best].key) best = rc;
                if (best == pos) break;
                t = heap_mem[pos];
                heap_mem[pos] = heap_mem[best];
                heap_mem[best] = t;
                pos = best;
            end
        end
        r.fill = heap_fill[FW-1:0];
        return r;
    endfunction

    // present one request word, hold it until taken, then log what should come back
    task automatic send_word(input logic op, input logic [KW-1:0] key, input logic [TW-1:0] tag,
                             input logic typed, input t_rsp_word want);
        t_rsp_word model;
        if (!quiet && $urandom_range(99) < gap_pct) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.op    <= op;
        req_if.key   <= key;
        req_if.tag   <= tag;
        do @(posedge i_clk); while (!req_if.ready);
        model = heap_apply(op, key, tag);
        pending_rsp.push_back(typed ? want : model);
        words_sent++;
    endtask

    task automatic send_random(input int ins_pct, input bit narrow);
        logic [KW-1:0] key;
        key = narrow ? KW'($urandom_range(0, 3)) : KW'($urandom_range(0, 63));
        send_word(($urandom_range(99) < ins_pct) ? OP_INSERT : OP_EXTRACT, key,
                  TW'($urandom), 1'b0, '0);
    endtask

    // response side stalls in bursts, long stretches of ready too
    initial begin
        rsp_if.ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (!quiet && $urandom_range(99) < 30) begin
                rsp_if.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
            rsp_if.ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_rsp_word got;
        t_rsp_word want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            got = '{rsp_if.status, rsp_if.out_key, rsp_if.out_tag, rsp_if.fill};
            if (pending_rsp.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected response word: status %0d key %0d tag %h fill %0d",
                             got.status, got.out_key, got.out_tag, got.fill);
            end else begin
                want = pending_rsp.pop_front();
                if (got.status !== want.status || got.out_key !== want.out_key ||
                    got.out_tag !== want.out_tag || got.fill !== want.fill) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display({"mismatch: expected status %0d key %0d tag %h fill %0d,",
                                  " got status %0d key %0d tag %h fill %0d"},
                                 want.status, want.out_key, want.out_tag, want.fill,
                                 got.status, got.out_key, got.out_tag, got.fill);
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    initial begin
        int seg_len;
        int ins_pct;
        bit narrow;
        heap_fill   = 0;
        fail_count  = 0;
        words_sent  = 0;
        gap_pct     = 0;
        quiet       = 1'b0;
        i_rst_n      <= 1'b0;
        req_if.valid <= 1'b0;
        req_if.op    <= OP_INSERT;
        req_if.key   <= '0;
        req_if.tag   <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        gap_pct = 25;
        for (int i = 0; i < N_DIR; i++) begin
            send_word(DIR_ROWS[i].op, DIR_ROWS[i].key, DIR_ROWS[i].tag,
                      DIR_ROWS[i].typed, DIR_ROWS[i].want);
        end

        // mixed segments with their own insert bias, key spread and gap rate
        while (words_sent < N_DIR + N_MIX) begin
            seg_len = $urandom_range(10, 40);
            ins_pct = $urandom_range(30, 80);
            narrow  = 1'($urandom_range(1));
            case ($urandom_range(2))
                0: gap_pct = 0;
                1: gap_pct = 20;
                default: gap_pct = 60;
            endcase
            repeat (seg_len) send_random(ins_pct, narrow);
        end

        // fill to the top, push past it, drain and pull past empty
        gap_pct = 15;
        while (heap_fill < DEPTH) send_random(100, 1'($urandom_range(1)));
        repeat (3) send_random(100, 1'b0);
        while (heap_fill > 0) send_random(0, 1'b0);
        repeat (3) send_random(0, 1'b0);

        quiet   = 1'b1;
        gap_pct = 0;
        repeat (N_TAIL) send_random(60, 1'($urandom_range(1)));
        req_if.valid <= 1'b0;

        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (fail_count == 0 && pending_rsp.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/bmh_pkg.sv
rtl/bmh_if.sv
rtl/bmh_datapath.sv
rtl/bmh_ctrl.sv
rtl/binary_min_heap_priority_queue.sv
tb/tb_binary_min_heap_priority_queue.sv
